/* rtl/core/kced_pkg.sv */
package kced_pkg;

  // counter width of the held, released and repeat tick counters
  localparam int unsigned CntW = 16;
  localparam int unsigned ThrW = 16;
  localparam int unsigned CmpW = (CntW > ThrW) ? CntW : ThrW;

  localparam int unsigned StateW = 3;
  localparam int unsigned EventW = 3;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 16;

  // key state codes
  localparam logic [StateW-1:0] StReleased = 3'd0;
  localparam logic [StateW-1:0] StDebounce = 3'd1;
  localparam logic [StateW-1:0] StPressed  = 3'd2;
  localparam logic [StateW-1:0] StLong     = 3'd3;
  localparam logic [StateW-1:0] StWait     = 3'd4;

  // event codes
  localparam logic [EventW-1:0] EvNone   = 3'd0;
  localparam logic [EventW-1:0] EvPress  = 3'd1;
  localparam logic [EventW-1:0] EvShort  = 3'd2;
  localparam logic [EventW-1:0] EvDouble = 3'd3;
  localparam logic [EventW-1:0] EvLong   = 3'd4;
  localparam logic [EventW-1:0] EvRepeat = 3'd5;

  // register indexes
  localparam logic [IdxW-1:0] RegPressLevel  = 3'd0;
  localparam logic [IdxW-1:0] RegDebounce    = 3'd1;
  localparam logic [IdxW-1:0] RegLongPress   = 3'd2;
  localparam logic [IdxW-1:0] RegDoubleClick = 3'd3;
  localparam logic [IdxW-1:0] RegRepeat      = 3'd4;

  typedef struct packed {
    logic            press_level;
    logic [ThrW-1:0] debounce_ticks;
    logic [ThrW-1:0] long_press_ticks;
    logic [ThrW-1:0] double_click_ticks;
    logic [ThrW-1:0] repeat_ticks;
  } kced_cfg_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic              is_pressed;
    logic              is_long_pressed;
  } kced_res_t;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic ge_thr(logic [CntW-1:0] c, logic [ThrW-1:0] t);
    return CmpW'(c) >= CmpW'(t);
  endfunction

endpackage

/* rtl/core/kced_cfg.sv */
module kced_cfg
  import kced_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [DataW-1:0] cfg_data_i,
  output kced_cfg_t        cfg_o
);

  kced_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPressLevel:  cfg_d.press_level        = cfg_data_i[0];
        RegDebounce:    cfg_d.debounce_ticks     = ThrW'(cfg_data_i);
        RegLongPress:   cfg_d.long_press_ticks   = ThrW'(cfg_data_i);
        RegDoubleClick: cfg_d.double_click_ticks = ThrW'(cfg_data_i);
        RegRepeat:      cfg_d.repeat_ticks       = ThrW'(cfg_data_i);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_level        <= 1'b0;
      cfg_q.debounce_ticks     <= ThrW'(1);
      cfg_q.long_press_ticks   <= ThrW'(50);
      cfg_q.double_click_ticks <= ThrW'(15);
      cfg_q.repeat_ticks       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/kced_fsm.sv */
module kced_fsm
  import kced_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      pin_level_i,
  input  kced_cfg_t cfg_i,
  output kced_res_t res_o
);

  logic [StateW-1:0] state_q, state_d;
  logic [CntW-1:0]   held_q, held_d;
  logic [CntW-1:0]   rel_q, rel_d;
  logic [CntW-1:0]   rpt_q, rpt_d;
  logic [1:0]        clicks_q, clicks_d;
  logic              long_fired_q, long_fired_d;
  logic [EventW-1:0] ev;
  logic              held;
  logic [CntW-1:0]   held_inc, rel_inc, rpt_inc;

  assign held     = (pin_level_i == cfg_i.press_level);
  assign held_inc = sat_inc(held_q);
  assign rel_inc  = sat_inc(rel_q);
  assign rpt_inc  = sat_inc(rpt_q);

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    rel_d        = rel_q;
    rpt_d        = rpt_q;
    clicks_d     = clicks_q;
    long_fired_d = long_fired_q;
    ev           = EvNone;
    case (state_q)
      StDebounce: begin
        if (held) begin
          held_d = held_inc;
          if (ge_thr(held_inc, cfg_i.debounce_ticks)) begin
            state_d = StPressed;
            ev      = EvPress;
            if (clicks_q != 2'd3) clicks_d = clicks_q + 2'd1;
            held_d  = '0;
          end
        end else begin
          state_d = StReleased;
        end
      end
      StPressed: begin
        if (!held) begin
          state_d = StDebounce;
          rel_d   = '0;
          if (!ge_thr(held_q, cfg_i.long_press_ticks)) begin
            if (clicks_q == 2'd1) begin
              state_d = StWait;
            end else if (clicks_q >= 2'd2) begin
              ev       = EvDouble;
              clicks_d = '0;
              state_d  = StReleased;
            end
          end else begin
            // long hold released before the long event fired
            ev       = EvShort;
            clicks_d = '0;
          end
          held_d       = '0;
          long_fired_d = 1'b0;
        end else begin
          held_d = held_inc;
          if (ge_thr(held_inc, cfg_i.long_press_ticks) && !long_fired_q) begin
            ev           = EvLong;
            long_fired_d = 1'b1;
            state_d      = StLong;
            rpt_d        = '0;
            clicks_d     = '0;
          end
        end
      end
      StLong: begin
        if (!held) begin
          state_d      = StDebounce;
          long_fired_d = 1'b0;
          held_d       = '0;
        end else begin
          rpt_d = rpt_inc;
          if ((cfg_i.repeat_ticks != '0) && ge_thr(rpt_inc, cfg_i.repeat_ticks)) begin
            ev    = EvRepeat;
            rpt_d = '0;
          end
        end
      end
      StWait: begin
        if (held) begin
          state_d = StDebounce;
          held_d  = '0;
          rel_d   = '0;
        end else begin
          rel_d = rel_inc;
          if (ge_thr(rel_inc, cfg_i.double_click_ticks)) begin
            if (clicks_q == 2'd1) ev = EvShort;
            state_d  = StReleased;
            clicks_d = '0;
          end
        end
      end
      default: begin
        // released, and unused codes behave the same
        if (held) begin
          state_d      = StDebounce;
          held_d       = '0;
          long_fired_d = 1'b0;
          rpt_d        = '0;
        end else begin
          state_d = StReleased;
        end
        rel_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StReleased;
      held_q       <= '0;
      rel_q        <= '0;
      rpt_q        <= '0;
      clicks_q     <= '0;
      long_fired_q <= 1'b0;
    end else if (step_i) begin
      state_q      <= state_d;
      held_q       <= held_d;
      rel_q        <= rel_d;
      rpt_q        <= rpt_d;
      clicks_q     <= clicks_d;
      long_fired_q <= long_fired_d;
    end
  end

  assign res_o.event_res       = ev;
  assign res_o.is_pressed      = (state_d == StPressed) || (state_d == StLong);
  assign res_o.is_long_pressed = (state_d == StLong);

  a_press_enters_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ev == EvPress) |=> (state_q == StPressed) && (held_q == '0))
    else $error("press event did not enter pressed state");

  a_long_sets_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ev == EvLong) |=> (state_q == StLong) && long_fired_q && (clicks_q == '0))
    else $error("long event did not enter long pressed state");

  a_repeat_only_in_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ev == EvRepeat) |-> (state_q == StLong) && (cfg_i.repeat_ticks != '0))
    else $error("repeat event outside long pressed or while disabled");

  a_released_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (state_q == StReleased) |=> (rel_q == '0))
    else $error("released ticks not cleared in released state");

endmodule

/* rtl/core/key_click_event_detector.sv */
// Button event detector: one raw pin sample is taken per transfer on the input
// channel and exactly one result (event code plus pressed and long-pressed flags)
// comes out for it, in order. A new sample is accepted every clock cycle while the
// output is not stalled; the key state update is one pass of logic between the input
// register and the result register, and a stalled output holds both stages until it
// is drained. Thresholds are tick counts written through the configuration channel,
// which is always ready and should only be written while no sample is in flight.
module key_click_event_detector
  import kced_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IdxW-1:0]   cfg_index_i,
  input  logic [DataW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              pin_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EventW-1:0] event_res_o,
  output logic              is_pressed_o,
  output logic              is_long_pressed_o
);

  kced_cfg_t cfg;
  kced_res_t res;
  kced_res_t res_q;
  logic      in_valid_q, in_valid_d;
  logic      pin_q;
  logic      out_valid_q, out_valid_d;
  logic      load_out, advance, in_take;

  kced_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign load_out   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && load_out;
  assign in_ready_o = !in_valid_q || load_out;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = load_out ? advance : out_valid_q;
  end

  kced_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .pin_level_i (pin_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) pin_q <= pin_level_i;
    if (advance) res_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = res_q.event_res;
  assign is_pressed_o      = res_q.is_pressed;
  assign is_long_pressed_o = res_q.is_long_pressed;

endmodule
